// File: rtl/rqu_pkg.sv
// shared widths and defaults for the relative quaternion unit
// no dependencies
package rqu_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int COMP_W        = 16;
    localparam int SUM_W         = 34;
    localparam int MAG_W         = 33;
    localparam int NORM_W        = 33;
    localparam int QUO_W         = 17;
    localparam int DIV_STEPS     = QUO_W;

    localparam logic signed [COMP_W-1:0] SAT_POS = 16'sh7fff;
    localparam logic signed [COMP_W-1:0] SAT_NEG = 16'sh8000;

    typedef struct packed {
        logic neg;
        logic ovf;
    } div_side_t;

endpackage

// File: rtl/relative_quaternion_unit_top.sv
// relative quaternion unit: inverse(reference) times current, pipelined
// depends on rqu_pkg and rqu_div_lane
//
// usage
// - slave channel: one beat carries a reference and a current quaternion,
//   each component signed fixed point with FRAC_BITS fraction bits
// - master channel: one beat per input beat, in order, carrying the four
//   components of conj(ref)*cur / |ref|^2, rounded toward zero and saturated
// - tuser flags zero_norm (reference all zero, components forced to zero)
//   and saturated (some component clipped)
// - stages: one multiply stage, one sum stage, one prepare stage,
//   17 divider stages (one quotient bit each), one output register
// - throughput one beat per cycle while the output is not stalled; the 17-stage divider sets the depth
// - when m_tready is low with a beat waiting, the whole pipeline holds and
//   s_tready drops; nothing is lost or repeated
// - reset clears all valid bits; payload registers are not reset
module relative_quaternion_unit_top #(
    parameter int FRAC_BITS = rqu_pkg::FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // ref_w, ref_x, ref_y, ref_z, cur_w, cur_x, cur_y, cur_z (16 bits each)
    input  logic [127:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // rel_w, rel_x, rel_y, rel_z (16 bits each)
    output logic [63:0]  m_tdata,
    // zero_norm, saturated
    output logic [1:0]   m_tuser
);

    localparam int CW    = rqu_pkg::COMP_W;
    localparam int SW    = rqu_pkg::SUM_W;
    localparam int MW    = rqu_pkg::MAG_W;
    localparam int NW    = rqu_pkg::NORM_W;
    localparam int QW    = rqu_pkg::QUO_W;
    localparam int NUM_W = MW + FRAC_BITS;
    localparam int TOP_W = NUM_W - QW;
    localparam int DEPTH = 3 + rqu_pkg::DIV_STEPS;

    // whole pipeline moves when the output register is free or being drained
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic [DEPTH-3:0] zero_reg;

    // unpack components
    logic signed [CW-1:0] r [0:3];
    logic signed [CW-1:0] c [0:3];
    for (genvar i = 0; i < 4; i++) begin : g_unpack
        assign r[i] = s_tdata[CW*i +: CW];
        assign c[i] = s_tdata[CW*(i+4) +: CW];
    end

    // stage 1: all products and squares
    logic signed [31:0] pr_reg [0:3][0:3];
    logic signed [31:0] sq_reg [0:3];
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int a = 0; a < 4; a++) begin
                sq_reg[a] <= r[a] * r[a];
                for (int b = 0; b < 4; b++) begin
                    pr_reg[a][b] <= r[a] * c[b];
                end
            end
        end
    end

    // stage 2: hamilton product of conj(ref) with cur, and squared norm
    logic signed [SW-1:0] p_reg [0:3];
    logic [NW-1:0]        n_reg;
    function automatic logic signed [SW-1:0] sx(input logic signed [31:0] v);
        return SW'(v);
    endfunction
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0] <= sx(pr_reg[0][0]) + sx(pr_reg[1][1]) + sx(pr_reg[2][2])
                      + sx(pr_reg[3][3]);
            p_reg[1] <= sx(pr_reg[0][1]) - sx(pr_reg[1][0]) - sx(pr_reg[2][3])
                      + sx(pr_reg[3][2]);
            p_reg[2] <= sx(pr_reg[0][2]) + sx(pr_reg[1][3]) - sx(pr_reg[2][0])
                      - sx(pr_reg[3][1]);
            p_reg[3] <= sx(pr_reg[0][3]) - sx(pr_reg[1][2]) + sx(pr_reg[2][1])
                      - sx(pr_reg[3][0]);
            n_reg    <= NW'(sq_reg[0]) + NW'(sq_reg[1]) + NW'(sq_reg[2]) + NW'(sq_reg[3]);
        end
    end

    // stage 3: magnitude, scale, early overflow test
    logic [TOP_W-1:0]    top_reg  [0:3];
    logic [QW-1:0]       low_reg  [0:3];
    rqu_pkg::div_side_t  side_reg [0:3];
    logic [NW-1:0]       nd_reg;
    for (genvar i = 0; i < 4; i++) begin : g_prep
        logic [MW-1:0]    mag;
        logic [NUM_W-1:0] num;
        always_comb begin
            mag = p_reg[i][SW-1] ? MW'(-p_reg[i]) : MW'(p_reg[i]);
            num = {mag, {FRAC_BITS{1'b0}}};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                top_reg[i]      <= num[NUM_W-1:QW];
                low_reg[i]      <= num[QW-1:0];
                side_reg[i].neg <= p_reg[i][SW-1];
                side_reg[i].ovf <= NW'(num[NUM_W-1:QW]) >= n_reg;
            end
        end
    end
    always_ff @(posedge aclk) begin
        if (en) begin
            nd_reg <= n_reg;
        end
    end

    // divider lanes
    logic [QW-1:0]      quo  [0:3];
    rqu_pkg::div_side_t side [0:3];
    for (genvar i = 0; i < 4; i++) begin : g_lane
        rqu_div_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
            .aclk     (aclk),
            .en       (en),
            .top_in   (top_reg[i]),
            .low_in   (low_reg[i]),
            .norm_in  ((i == 0) ? nd_reg : nd_reg),
            .side_in  (side_reg[i]),
            .quo_out  (quo[i]),
            .side_out (side[i])
        );
    end

    // zero flag travels beside the valid bits; set at stage 2 output
    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg <= {zero_reg[DEPTH-4:0], (n_reg == '0)};
        end
    end

    // saturation into output register
    logic [CW-1:0] rel_next [0:3];
    logic [3:0]    clip;
    for (genvar i = 0; i < 4; i++) begin : g_sat
        always_comb begin
            clip[i]     = 1'b0;
            rel_next[i] = '0;
            if (!side[i].neg) begin
                if (side[i].ovf || quo[i] > QW'(32767)) begin
                    clip[i]     = 1'b1;
                    rel_next[i] = rqu_pkg::SAT_POS;
                end else begin
                    rel_next[i] = quo[i][CW-1:0];
                end
            end else begin
                if (side[i].ovf || quo[i] > QW'(32768)) begin
                    clip[i]     = 1'b1;
                    rel_next[i] = rqu_pkg::SAT_NEG;
                end else begin
                    rel_next[i] = CW'(-quo[i]);
                end
            end
        end
    end

    // zero flag lined up with the divider outputs
    logic zero_now;
    assign zero_now = zero_reg[DEPTH-3];

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                m_tdata[CW*i +: CW] <= zero_now ? '0 : rel_next[i];
            end
            m_tuser <= {(!zero_now && (clip != '0)), zero_now};
        end
    end

    assign vld_next = {vld_reg[DEPTH-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg  <= '0;
            m_tvalid <= 1'b0;
        end else if (en) begin
            vld_reg  <= vld_next;
            m_tvalid <= vld_reg[DEPTH-1];
        end
    end

endmodule

// File: rtl/rqu_div_lane.sv
// one lane of the restoring divider, one quotient bit per stage
// depends on rqu_pkg
module rqu_div_lane #(
    parameter int FRAC_BITS = rqu_pkg::FRAC_BITS_DEF
) (
    input  logic                                         aclk,
    input  logic                                         en,
    input  logic [rqu_pkg::MAG_W+FRAC_BITS-rqu_pkg::QUO_W-1:0] top_in,
    input  logic [rqu_pkg::QUO_W-1:0]                    low_in,
    input  logic [rqu_pkg::NORM_W-1:0]                   norm_in,
    input  rqu_pkg::div_side_t                           side_in,
    output logic [rqu_pkg::QUO_W-1:0]                    quo_out,
    output rqu_pkg::div_side_t                           side_out
);

    localparam int STEPS = rqu_pkg::DIV_STEPS;
    localparam int NW    = rqu_pkg::NORM_W;
    localparam int QW    = rqu_pkg::QUO_W;

    logic [NW-1:0]      rem_reg  [0:STEPS];
    logic [QW-1:0]      low_reg  [0:STEPS];
    logic [QW-1:0]      quo_reg  [0:STEPS];
    logic [NW-1:0]      norm_reg [0:STEPS];
    rqu_pkg::div_side_t side_reg [0:STEPS];

    // stage 0 holds the partial remainder below the norm unless overflow is flagged
    always_comb begin
        rem_reg[0]  = NW'(top_in);
        low_reg[0]  = low_in;
        quo_reg[0]  = '0;
        norm_reg[0] = norm_in;
        side_reg[0] = side_in;
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_step
        logic [NW:0]   trial;
        logic          ge;
        logic [NW-1:0] rem_next;

        always_comb begin
            trial    = {rem_reg[k], low_reg[k][QW-1]};
            ge       = trial >= {1'b0, norm_reg[k]};
            rem_next = ge ? NW'(trial - {1'b0, norm_reg[k]}) : trial[NW-1:0];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= rem_next;
                low_reg[k+1]  <= {low_reg[k][QW-2:0], 1'b0};
                quo_reg[k+1]  <= {quo_reg[k][QW-2:0], ge};
                norm_reg[k+1] <= norm_reg[k];
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign quo_out  = quo_reg[STEPS];
    assign side_out = side_reg[STEPS];

endmodule

// File: rtl/rqu_checker.sv
// port-level checks for the relative quaternion unit, bound to the top level
// depends on relative_quaternion_unit_top
module rqu_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [63:0]  m_tdata,
    input logic [1:0]   m_tuser
);

    a_zero_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == '0 && !m_tuser[1])
        else $error("zero norm beat with non-zero payload");

    a_sat_val: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |->
            m_tdata[15:0] == 16'h7fff || m_tdata[15:0] == 16'h8000 ||
            m_tdata[31:16] == 16'h7fff || m_tdata[31:16] == 16'h8000 ||
            m_tdata[47:32] == 16'h7fff || m_tdata[47:32] == 16'h8000 ||
            m_tdata[63:48] == 16'h7fff || m_tdata[63:48] == 16'h8000)
        else $error("saturated flag without a clipped component");

    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled beat changed");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind relative_quaternion_unit_top rqu_checker u_rqu_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
